// ===== hdl/stle_pkg.sv =====
// ----------------------------------------------------------------------------
// stle_pkg: shared types and constants for the session table
// Field widths, action codes and reset values of the LRU session table.
// ----------------------------------------------------------------------------
package stle_pkg;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam int ID_W            = 64;
  localparam int TIME_W          = 32;
  localparam int SLOT_W          = 4;
  localparam int CLOSED_W        = 5;

  localparam logic [TIME_W-1:0] IDLE_TTL_RST = 32'd3600;

  typedef enum logic [1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_CREATE  = 2'd1,
    ACT_SWEEP   = 2'd2,
    ACT_DESTROY = 2'd3
  } action_t;

endpackage

// ===== hdl/session_table_lru_evict_top.sv =====
// ----------------------------------------------------------------------------
// session_table_lru_evict_top: session table with LRU eviction
// Lookup, create, sweep and destroy over a table of session entries, scanned
// one entry per cycle through a single read port and one shared comparator.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid/in_ready    action, id, time, slot
//   out_     output     out_valid/out_ready  found, slot, eviction, count
//   cfg_     input      cfg_wr_en            idle_ttl
//
// Lookup and create scan through a read lead-in, then one read per cycle from
// the entry memory, then a write-back on a lookup hit or a create; sweep scans
// without a write-back. Lookup ends early on a hit, create on the first free
// slot. Destroy, lookup of id zero and a sweep before now reaches idle_ttl
// skip the scan and go straight to the result. in_ready is high only while
// the sequencer is idle and rises with the result load; a held result does
// not stop the next beat, only the loading of its result. Reset empties the
// table at once through per-entry valid flags.
// ----------------------------------------------------------------------------
module session_table_lru_evict_top #(
  parameter int ENTRY_COUNT = stle_pkg::ENTRY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [stle_pkg::ID_W-1:0]     in_session_id,
  input  logic [stle_pkg::TIME_W-1:0]   in_now_seconds,
  input  logic [stle_pkg::SLOT_W-1:0]   in_slot_index,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [stle_pkg::SLOT_W-1:0]   out_result_slot,
  output logic                          out_evicted,
  output logic [stle_pkg::ID_W-1:0]     out_evicted_id,
  output logic [stle_pkg::CLOSED_W-1:0] out_closed_count,

  input  logic                          cfg_wr_en,
  input  logic [stle_pkg::TIME_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam int ID_W   = stle_pkg::ID_W;
  localparam int TIME_W = stle_pkg::TIME_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r;
  stle_pkg::action_t     act_r;
  logic [ID_W-1:0]       sid_r;
  logic [TIME_W-1:0]     now_r;
  logic [TIME_W-1:0]     thresh_r;
  logic [TIME_W-1:0]     ttl_r;

  logic [ENTRY_COUNT-1:0] valid_r;
  logic [ID_W-1:0]        id_mem   [ENTRY_COUNT];
  logic [TIME_W-1:0]      time_mem [ENTRY_COUNT];
  logic [ID_W-1:0]        rd_id_r;
  logic [TIME_W-1:0]      rd_time_r;

  logic [CNT_W-1:0]      rd_cnt_r;
  logic [IDX_W-1:0]      ev_idx_r;
  logic                  ev_vld_r;

  logic [IDX_W-1:0]      tgt_r;
  logic                  found_r;
  logic                  evicted_r;
  logic [ID_W-1:0]       evicted_id_r;
  logic [CNT_W-1:0]      closed_r;
  logic [IDX_W-1:0]      old_idx_r;
  logic [TIME_W-1:0]     old_time_r;
  logic [ID_W-1:0]       old_id_r;

  logic                  in_fire;
  logic                  rd_more;
  logic [IDX_W-1:0]      rd_addr;
  logic [ID_W-1:0]       cur_id;
  logic [TIME_W-1:0]     cur_time;
  logic [TIME_W-1:0]     cmp_b;
  logic                  cmp_lt;
  logic                  last_ev;
  logic                  take_old;
  logic [IDX_W-1:0]      old_idx_nxt;
  logic [ID_W-1:0]       old_id_nxt;
  logic [IDX_W+3:0]      slot_ext;
  logic                  slot_ok;
  logic [IDX_W+3:0]      tgt_ext;
  logic [CNT_W+4:0]      closed_ext;
  logic                  load_out;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign rd_more = (rd_cnt_r < CNT_W'(ENTRY_COUNT));
  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  assign cur_id   = valid_r[ev_idx_r] ? rd_id_r   : '0;
  assign cur_time = valid_r[ev_idx_r] ? rd_time_r : '0;

  // shared comparator: oldest-so-far on create, expiry threshold on sweep
  assign cmp_b  = (act_r == stle_pkg::ACT_CREATE) ? old_time_r : thresh_r;
  assign cmp_lt = (cur_time < cmp_b);

  assign last_ev  = ev_vld_r && (ev_idx_r == IDX_W'(ENTRY_COUNT - 1));
  assign take_old = (ev_idx_r == '0) || cmp_lt;
  assign old_idx_nxt = take_old ? ev_idx_r : old_idx_r;
  assign old_id_nxt  = take_old ? cur_id   : old_id_r;

  assign slot_ext = (IDX_W+4)'(in_slot_index);
  assign slot_ok  = (slot_ext < (IDX_W+4)'(ENTRY_COUNT));

  assign load_out = (state_r == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= stle_pkg::IDLE_TTL_RST;
    end else if (cfg_wr_en) begin
      ttl_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_id_r   <= id_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
    if (state_r == S_WRITE) begin
      time_mem[tgt_r] <= now_r;
      if (act_r == stle_pkg::ACT_CREATE) begin
        id_mem[tgt_r] <= sid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= stle_pkg::action_t'(in_action);
      sid_r    <= in_session_id;
      now_r    <= in_now_seconds;
      thresh_r <= in_now_seconds - ttl_r;
    end
    if (ev_vld_r && (state_r == S_SCAN) && (act_r == stle_pkg::ACT_CREATE) && take_old) begin
      old_idx_r  <= ev_idx_r;
      old_time_r <= cur_time;
      old_id_r   <= cur_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      rd_cnt_r     <= '0;
      ev_idx_r     <= '0;
      ev_vld_r     <= 1'b0;
      tgt_r        <= '0;
      found_r      <= 1'b0;
      evicted_r    <= 1'b0;
      evicted_id_r <= '0;
      closed_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            rd_cnt_r     <= '0;
            ev_vld_r     <= 1'b0;
            tgt_r        <= '0;
            found_r      <= 1'b0;
            evicted_r    <= 1'b0;
            evicted_id_r <= '0;
            closed_r     <= '0;
            case (stle_pkg::action_t'(in_action))
              stle_pkg::ACT_LOOKUP: begin
                state_r <= (in_session_id == '0) ? S_DONE : S_SCAN;
              end
              stle_pkg::ACT_CREATE: begin
                state_r <= S_SCAN;
              end
              stle_pkg::ACT_SWEEP: begin
                state_r <= (in_now_seconds >= ttl_r) ? S_SCAN : S_DONE;
              end
              default: begin
                if (slot_ok) begin
                  valid_r[slot_ext[IDX_W-1:0]] <= 1'b0;
                end
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          ev_vld_r <= rd_more;
          ev_idx_r <= rd_addr;
          if (rd_more) begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
          if (ev_vld_r) begin
            case (act_r)
              stle_pkg::ACT_LOOKUP: begin
                if (cur_id == sid_r) begin
                  found_r <= 1'b1;
                  tgt_r   <= ev_idx_r;
                  state_r <= S_WRITE;
                end else if (last_ev) begin
                  state_r <= S_DONE;
                end
              end
              stle_pkg::ACT_CREATE: begin
                if (cur_id == '0) begin
                  found_r <= 1'b1;
                  tgt_r   <= ev_idx_r;
                  state_r <= S_WRITE;
                end else if (last_ev) begin
                  found_r      <= 1'b1;
                  tgt_r        <= old_idx_nxt;
                  evicted_r    <= 1'b1;
                  evicted_id_r <= old_id_nxt;
                  state_r      <= S_WRITE;
                end
              end
              default: begin
                if ((cur_id != '0) && cmp_lt) begin
                  valid_r[ev_idx_r] <= 1'b0;
                  closed_r          <= closed_r + CNT_W'(1);
                end
                if (last_ev) begin
                  state_r <= S_DONE;
                end
              end
            endcase
          end
        end
        S_WRITE: begin
          if (act_r == stle_pkg::ACT_CREATE) begin
            valid_r[tgt_r] <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign tgt_ext    = (IDX_W+4)'(tgt_r);
  assign closed_ext = (CNT_W+5)'(closed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found        <= found_r;
      out_result_slot  <= tgt_ext[3:0];
      out_evicted      <= evicted_r;
      out_evicted_id   <= evicted_id_r;
      out_closed_count <= closed_ext[4:0];
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_create_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && act_r == stle_pkg::ACT_CREATE) |-> found_r)
    else $error("create reached write-back without a target");

  a_evict_only_create: assert property (@(posedge clk) disable iff (!rst_n)
    evicted_r |-> (act_r == stle_pkg::ACT_CREATE))
    else $error("eviction flagged outside create");

  a_destroy_short: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == stle_pkg::ACT_DESTROY) |=> (state_r == S_DONE))
    else $error("destroy did not finish at once");

  a_closed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (closed_r <= CNT_W'(ENTRY_COUNT)))
    else $error("sweep count beyond table size");

  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (state_r == S_DONE))
    else $error("write-back held longer than one cycle");
`endif

endmodule
